// ===== hw/rtl/sbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_pkg: shared constants for the decimal text converter
// Holds the value width, the digit count and the character codes.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int unsigned ValueBitsDefault = 64;
  localparam int unsigned DigitCount       = 20;
  localparam int unsigned DigitIdxBits     = 5;
  localparam logic [7:0]  CharZero         = 8'h30;
  localparam logic [7:0]  CharMinus        = 8'h2D;

endpackage

// ===== hw/rtl/sbd_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_stage: one pipeline stage of the double-dabble converter
// Shifts STEP magnitude bits into the BCD digits, adjusting before each shift.
// ----------------------------------------------------------------------------
module sbd_stage #(
  parameter int unsigned VALUE_BITS = sbd_pkg::ValueBitsDefault,
  parameter int unsigned STEP       = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic                                   in_negative,
  input  logic [VALUE_BITS-1:0]                  in_mag,
  input  logic [sbd_pkg::DigitCount-1:0][3:0]    in_bcd,
  output logic                                   out_valid,
  output logic                                   out_negative,
  output logic [VALUE_BITS-1:0]                  out_mag,
  output logic [sbd_pkg::DigitCount-1:0][3:0]    out_bcd
);

  logic [VALUE_BITS-1:0]               mag_next;
  logic [sbd_pkg::DigitCount-1:0][3:0] bcd_next;

  always_comb begin
    mag_next = in_mag;
    bcd_next = in_bcd;
    for (int s = 0; s < int'(STEP); s++) begin
      for (int d = 0; d < int'(sbd_pkg::DigitCount); d++) begin
        if (bcd_next[d] >= 4'd5) begin
          bcd_next[d] = bcd_next[d] + 4'd3;
        end
      end
      bcd_next = (bcd_next << 1) |
                 {{(sbd_pkg::DigitCount*4-1){1'b0}}, mag_next[VALUE_BITS-1]};
      mag_next = {mag_next[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_negative <= in_negative;
      out_mag      <= mag_next;
      out_bcd      <= bcd_next;
    end
  end

endmodule

// ===== hw/rtl/signed_binary_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts each value with a pipelined double-dabble and streams its
// characters, most significant first, with a flag on the last character.
// ----------------------------------------------------------------------------
//  channel  signals                      direction  meaning
//  input    valid, ready, value          in         one signed integer
//  output   valid, ready, text_char,     out        one character per item,
//           last_char                               last_char on the final one
//
// An item enters the converter pipeline in any cycle its first stage can
// advance; the conversion passes through ceil(VALUE_BITS/8) register stages
// (eight adjust-and-shift steps each), and then into the emitter register,
// from which the first character is offered. The character emitter sends one
// character per cycle while out_ready is high, so a number gives 1 to 20
// characters and that sets the sustained rate. Once the last stage holds a
// finished item, a stall on the output holds the whole pipeline in place;
// nothing is dropped or repeated. rst clears all valid bits.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core #(
  parameter int unsigned VALUE_BITS = sbd_pkg::ValueBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [63:0]     value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             text_char,
  output logic                   last_char
);

  localparam int unsigned Step   = 8;
  localparam int unsigned Stages = (VALUE_BITS + Step - 1) / Step;
  localparam int unsigned PadBits = Stages * Step;
  localparam int unsigned DC     = sbd_pkg::DigitCount;
  localparam int unsigned IB     = sbd_pkg::DigitIdxBits;

  // Pipeline chain, entry 0 is the input side.
  logic                          st_valid [Stages+1];
  logic                          st_neg   [Stages+1];
  logic [PadBits-1:0]            st_mag   [Stages+1];
  logic [DC-1:0][3:0]            st_bcd   [Stages+1];

  // Emitter state.
  logic                          busy;
  logic [DC-1:0][3:0]            digits;   // index 0 is the least significant
  logic                          sign_pending;
  logic [IB-1:0]                 pos;
  logic                          advance;
  logic                          emit_done;

  logic [VALUE_BITS-1:0]         raw;
  logic [VALUE_BITS-1:0]         mag_in;
  logic [IB-1:0]                 top_next;

  // Take the low bits, form the magnitude as unsigned so the most negative
  // value converts exactly, and left-align it in the padded shift word.
  assign raw    = value[VALUE_BITS-1:0];
  assign mag_in = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

  assign st_valid[0] = in_valid;
  assign st_neg[0]   = raw[VALUE_BITS-1];
  assign st_mag[0]   = PadBits'(mag_in) << (PadBits - VALUE_BITS);
  assign st_bcd[0]   = '0;

  // The whole pipeline advances unless the finished item cannot leave.
  assign emit_done = busy && !sign_pending && (pos == '0) && out_ready;
  assign advance   = !st_valid[Stages] || !busy || emit_done;
  assign in_ready  = advance;

  for (genvar g = 0; g < int'(Stages); g++) begin : g_stage
    sbd_stage #(.VALUE_BITS(PadBits), .STEP(Step)) u_stage (
      .clk          (clk),
      .rst          (rst),
      .en           (advance),
      .in_valid     (st_valid[g]),
      .in_negative  (st_neg[g]),
      .in_mag       (st_mag[g]),
      .in_bcd       (st_bcd[g]),
      .out_valid    (st_valid[g+1]),
      .out_negative (st_neg[g+1]),
      .out_mag      (st_mag[g+1]),
      .out_bcd      (st_bcd[g+1])
    );
  end

  // Find the most significant non-zero digit; zero keeps index 0.
  always_comb begin
    top_next = '0;
    for (int d = 0; d < int'(DC); d++) begin
      if (st_bcd[Stages][d] != 4'd0) begin
        top_next = IB'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      sign_pending <= 1'b0;
      pos          <= '0;
    end else begin
      if (advance && st_valid[Stages]) begin
        // Load the next finished item into the emitter.
        busy         <= 1'b1;
        sign_pending <= st_neg[Stages];
        pos          <= top_next;
      end else if (emit_done) begin
        busy <= 1'b0;
      end else if (busy && out_ready) begin
        if (sign_pending) begin
          sign_pending <= 1'b0;
        end else begin
          pos <= pos - 1'b1;
        end
      end
    end
    if (advance && st_valid[Stages]) begin
      digits <= st_bcd[Stages];
    end
  end

  assign out_valid = busy;
  assign text_char = sign_pending ? sbd_pkg::CharMinus
                                  : (sbd_pkg::CharZero | {4'd0, digits[pos]});
  assign last_char = !sign_pending && (pos == '0);

endmodule

// ===== bench/signed_binary_to_decimal_ascii_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core_tb: decimal text converter testbench
// Sends signed integers through the valid/ready input, predicts the ASCII
// characters of each one and compares every character and its last flag.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core_tb;

  localparam int unsigned ValueBits = sbd_pkg::ValueBitsDefault;
  localparam int unsigned CycleLimit = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [63:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         text_char;
  logic               last_char;

  // Expected characters, oldest first: {last flag, character}.
  logic [8:0] char_queue[$];
  int unsigned mismatches = 0;
  int unsigned chars_seen = 0;
  int unsigned numbers_sent = 0;
  int unsigned cycles = 0;
  bit          idle_enable = 1'b1;

  signed_binary_to_decimal_ascii_core #(.VALUE_BITS(ValueBits)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .text_char(text_char), .last_char(last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Push the decimal text of one value onto the expected queue.
  function automatic void predict_text(logic [63:0] v);
    logic [63:0] sign_bit;
    logic [63:0] mask;
    logic [63:0] raw;
    logic [63:0] mag;
    logic [7:0]  digit_chars[$];
    bit          negative;
    sign_bit = 64'd1 << (ValueBits - 1);
    mask     = (sign_bit << 1) - 64'd1;
    raw      = v & mask;
    negative = (raw & sign_bit) != 0;
    // unsigned negation keeps the most negative value exact
    mag      = negative ? ((~raw + 64'd1) & mask) : raw;
    if (mag == 0) digit_chars.push_front(sbd_pkg::CharZero);
    while (mag != 0) begin
      digit_chars.push_front(sbd_pkg::CharZero + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end
    if (negative) char_queue.push_back({1'b0, sbd_pkg::CharMinus});
    foreach (digit_chars[i])
      char_queue.push_back({i == digit_chars.size() - 1, digit_chars[i]});
  endfunction

  // Drive one number and hold it until the block takes it.
  task automatic send_number(logic [63:0] v);
    if (idle_enable && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 36);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_text(v);
    numbers_sent++;
    @(negedge clk);
  endtask

  // Randomise the output stall on the falling edge.
  always @(negedge clk) begin
    if (!rst) out_ready <= idle_enable ? ($urandom_range(99) >= 36) : 1'b1;
  end

  // Check each accepted character against the oldest expectation.
  always @(posedge clk) begin
    logic [8:0] want;
    if (!rst && out_valid && out_ready) begin
      chars_seen++;
      if (char_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char %h last %b", text_char, last_char);
      end else begin
        want = char_queue.pop_front();
        if (want[7:0] !== text_char || want[8] !== last_char) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected char %h last %b, got %h last %b",
                     want[7:0], want[8], text_char, last_char);
        end
      end
    end
  end

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_extremes();
    send_number(64'd0);
    send_number(64'd1);
    send_number(-64'sd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(-64'sd10);
    send_number(64'd99);
    send_number(64'd100);
    send_number(64'h7FFF_FFFF_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0000);   // most negative value
    send_number(64'h8000_0000_0000_0001);
    send_number(64'h7FFF_FFFF_FFFF_FFFE);
    send_number(64'd1_000_000_000_000_000_000);
    send_number(64'd999_999_999_999_999_999);
    send_number(64'hAAAA_AAAA_AAAA_AAAA);
    send_number(64'h5555_5555_5555_5555);
  endtask

  // Random numbers, with the magnitude spread across all digit counts.
  task automatic test_random(int unsigned count);
    logic [63:0] v;
    repeat (count) begin
      v = {$urandom, $urandom};
      case ($urandom_range(3))
        0: v = v >> $urandom_range(63);
        1: v = -(v >> $urandom_range(63));
        default: ;
      endcase
      send_number(v);
    end
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random(200);
    // a stretch with both sides busy every cycle
    idle_enable = 1'b0;
    test_random(80);
    idle_enable = 1'b1;
    test_random(164);
    in_valid <= 1'b0;
    wait_drained();
    $display("sent %0d numbers, checked %0d characters", numbers_sent, chars_seen);
    $display("covered zero, both signs, extremes and all digit counts");
    if (mismatches == 0 && char_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sbd_pkg.sv
hw/rtl/sbd_stage.sv
hw/rtl/signed_binary_to_decimal_ascii_core.sv
bench/signed_binary_to_decimal_ascii_core_tb.sv
